// ----- hw/rtl/y86dec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86dec_pkg
// Shared types and opcode constants for the Y86-64 instruction decoder.
// ----------------------------------------------------------------------------
package y86dec_pkg;

  // Instruction class reported on the result channel
  typedef enum logic [3:0] {
    KIND_HALT   = 4'd0,
    KIND_NOP    = 4'd1,
    KIND_CMOV   = 4'd2,
    KIND_IRMOV  = 4'd3,
    KIND_RMMOV  = 4'd4,
    KIND_MRMOV  = 4'd5,
    KIND_OPQ    = 4'd6,
    KIND_JUMP   = 4'd7,
    KIND_CALL   = 4'd8,
    KIND_RET    = 4'd9,
    KIND_PUSH   = 4'd10,
    KIND_POP    = 4'd11,
    KIND_BAD    = 4'd12
  } kind_t;

  // Decode status
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_HALT = 2'd1,
    ST_ADR  = 2'd2,
    ST_INS  = 2'd3
  } status_t;

  // Register field value meaning "no register"
  localparam logic [3:0] NONE_REG = 4'hF;

  // Opcode bytes
  localparam logic [7:0] OP_HALT    = 8'h00;
  localparam logic [7:0] OP_NOP     = 8'h10;
  localparam logic [7:0] OP_CMOV_LO = 8'h20;
  localparam logic [7:0] OP_CMOV_HI = 8'h26;
  localparam logic [7:0] OP_IRMOV   = 8'h30;
  localparam logic [7:0] OP_RMMOV   = 8'h40;
  localparam logic [7:0] OP_MRMOV   = 8'h50;
  localparam logic [7:0] OP_OPQ_LO  = 8'h60;
  localparam logic [7:0] OP_OPQ_HI  = 8'h63;
  localparam logic [7:0] OP_JMP_LO  = 8'h70;
  localparam logic [7:0] OP_JMP_HI  = 8'h76;
  localparam logic [7:0] OP_CALL    = 8'h80;
  localparam logic [7:0] OP_RET     = 8'h90;
  localparam logic [7:0] OP_PUSH    = 8'hA0;
  localparam logic [7:0] OP_POP     = 8'hB0;

  // Instruction lengths in bytes
  localparam logic [3:0] LEN_1  = 4'd1;
  localparam logic [3:0] LEN_2  = 4'd2;
  localparam logic [3:0] LEN_9  = 4'd9;
  localparam logic [3:0] LEN_10 = 4'd10;

  // Opcode decode result handed from the decoder to the pipeline
  typedef struct packed {
    kind_t      kind;
    logic [3:0] len;
    logic       op_ok;     // opcode byte is a legal encoding
    logic       has_regs;  // instruction carries a register byte
    logic       sel_val2;  // constant from bytes 2..9
    logic       sel_val1;  // constant from bytes 1..8
  } op_info_t;

endpackage

// ----- hw/rtl/y86dec_opdec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86dec_opdec
// Opcode byte decoder: class, length, register byte and constant layout.
// ----------------------------------------------------------------------------
module y86dec_opdec import y86dec_pkg::*; (
  input  logic [7:0] op,
  output op_info_t   info
);

  // Map opcode byte to its class and encoding
  always_comb begin
    info          = '0;
    info.kind     = KIND_BAD;
    info.has_regs = 1'b1;
    case (op) inside
      OP_HALT: begin
        info.kind = KIND_HALT; info.len = LEN_1; info.op_ok = 1'b1;
        info.has_regs = 1'b0;
      end
      OP_NOP: begin
        info.kind = KIND_NOP; info.len = LEN_1; info.op_ok = 1'b1;
        info.has_regs = 1'b0;
      end
      [OP_CMOV_LO:OP_CMOV_HI]: begin
        info.kind = KIND_CMOV; info.len = LEN_2; info.op_ok = 1'b1;
      end
      OP_IRMOV: begin
        info.kind = KIND_IRMOV; info.len = LEN_10; info.op_ok = 1'b1;
        info.sel_val2 = 1'b1;
      end
      OP_RMMOV: begin
        info.kind = KIND_RMMOV; info.len = LEN_10; info.op_ok = 1'b1;
        info.sel_val2 = 1'b1;
      end
      OP_MRMOV: begin
        info.kind = KIND_MRMOV; info.len = LEN_10; info.op_ok = 1'b1;
        info.sel_val2 = 1'b1;
      end
      [OP_OPQ_LO:OP_OPQ_HI]: begin
        info.kind = KIND_OPQ; info.len = LEN_2; info.op_ok = 1'b1;
      end
      [OP_JMP_LO:OP_JMP_HI]: begin
        info.kind = KIND_JUMP; info.len = LEN_9; info.op_ok = 1'b1;
        info.has_regs = 1'b0; info.sel_val1 = 1'b1;
      end
      OP_CALL: begin
        info.kind = KIND_CALL; info.len = LEN_9; info.op_ok = 1'b1;
        info.has_regs = 1'b0; info.sel_val1 = 1'b1;
      end
      OP_RET: begin
        info.kind = KIND_RET; info.len = LEN_1; info.op_ok = 1'b1;
        info.has_regs = 1'b0;
      end
      OP_PUSH: begin
        info.kind = KIND_PUSH; info.len = LEN_2; info.op_ok = 1'b1;
      end
      OP_POP: begin
        info.kind = KIND_POP; info.len = LEN_2; info.op_ok = 1'b1;
      end
      default: begin
        info.kind = KIND_BAD; info.op_ok = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/y86_instruction_decode_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86_instruction_decode_unit
// Three-stage Y86-64 instruction decoder with valid/stall channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries the PC and ten instruction bytes (in_instr_lo holds
//   bytes 0..7, in_instr_hi bytes 8..9). A transaction is taken on a rising
//   edge with in_valid high and in_stall low.
//   Result channel carries class, length, function code, register fields,
//   the 64-bit constant and a status (ok, halt, address error, invalid).
//   Throughput is one transaction per cycle while in_stall is low. A
//   transaction passes through the three register stages in order:
//     stage 1 - opcode decode and constant select
//     stage 2 - address range and register field checks, status
//     stage 3 - error masking into the output register
//   Each stage holds a valid bit; a stage whose next stage is empty still
//   loads while the output stalls, so bubbles collapse. With out_stall high
//   and the pipe full, in_stall goes high in the same cycle and nothing is
//   dropped or repeated.
//   Reset (rst_n low, synchronous) empties all stages; no result is pending.
// ----------------------------------------------------------------------------
module y86_instruction_decode_unit import y86dec_pkg::*; #(
  parameter int MEM_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [12:0] in_pc,
  input  logic [63:0] in_instr_lo,
  input  logic [15:0] in_instr_hi,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [3:0]  out_length,
  output logic [3:0]  out_func_code,
  output logic [3:0]  out_reg_a,
  output logic [3:0]  out_reg_b,
  output logic [63:0] out_constant,
  output logic [1:0]  out_status
);

  // Compare width covers both the memory size and pc + length
  localparam int LimW = $clog2(MEM_BYTES + 1);
  localparam int CmpW = (LimW > 14) ? LimW : 14;
  localparam logic [CmpW-1:0] MemLim = CmpW'(MEM_BYTES);

  // Stage enables
  logic s1_en, s2_en, s3_en;

  // Stage 1 registers
  logic        s1_v_r,    s1_v_nxt;
  logic [12:0] s1_pc_r,   s1_pc_nxt;
  op_info_t    s1_info_r, s1_info_nxt;
  logic [3:0]  s1_fn_r,   s1_fn_nxt;
  logic [3:0]  s1_ra_r,   s1_ra_nxt;
  logic [3:0]  s1_rb_r,   s1_rb_nxt;
  logic [63:0] s1_cval_r, s1_cval_nxt;

  // Stage 2 registers
  logic        s2_v_r,    s2_v_nxt;
  kind_t       s2_kind_r, s2_kind_nxt;
  logic [3:0]  s2_len_r,  s2_len_nxt;
  logic [3:0]  s2_fn_r;
  logic [3:0]  s2_ra_r;
  logic [3:0]  s2_rb_r;
  logic [63:0] s2_cval_r;
  status_t     s2_st_r,   s2_st_nxt;

  // Output registers
  logic        out_v_r,    out_v_nxt;
  logic [3:0]  out_kind_r, out_kind_nxt;
  logic [3:0]  out_len_r,  out_len_nxt;
  logic [3:0]  out_fn_r,   out_fn_nxt;
  logic [3:0]  out_ra_r,   out_ra_nxt;
  logic [3:0]  out_rb_r,   out_rb_nxt;
  logic [63:0] out_cval_r, out_cval_nxt;
  logic [1:0]  out_st_r,   out_st_nxt;

  // Stage 2 working signals
  logic [CmpW-1:0] s2_end;
  logic            pc_oob, end_oob, reg_bad;

  // Handshake: a stage loads when it is empty or its content moves on
  assign s3_en    = !out_v_r || !out_stall;
  assign s2_en    = !s2_v_r || s3_en;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_stall = !s1_en;

  // ---------------- Stage 1: opcode decode ----------------
  y86dec_opdec u_opdec (
    .op   (in_instr_lo[7:0]),
    .info (s1_info_nxt)
  );

  always_comb begin
    s1_v_nxt  = in_valid;
    s1_pc_nxt = in_pc;
    s1_fn_nxt = in_instr_lo[3:0];
    s1_ra_nxt = s1_info_nxt.has_regs ? in_instr_lo[15:12] : NONE_REG;
    s1_rb_nxt = s1_info_nxt.has_regs ? in_instr_lo[11:8]  : NONE_REG;
    // Constant: bytes 2..9 or bytes 1..8, zero otherwise
    if (s1_info_nxt.sel_val2) begin
      s1_cval_nxt = {in_instr_hi, in_instr_lo[63:16]};
    end else if (s1_info_nxt.sel_val1) begin
      s1_cval_nxt = {in_instr_hi[7:0], in_instr_lo[63:8]};
    end else begin
      s1_cval_nxt = '0;
    end
  end

  // ---------------- Stage 2: range and register checks ----------------
  always_comb begin
    s2_v_nxt    = s1_v_r;
    s2_kind_nxt = s1_info_r.kind;
    s2_len_nxt  = s1_info_r.len;
    s2_end      = CmpW'(s1_pc_r) + CmpW'(s1_info_r.len);
    pc_oob      = CmpW'(s1_pc_r) >= MemLim;
    end_oob     = s2_end > MemLim;
    reg_bad     = 1'b0;
    case (s1_info_r.kind)
      KIND_CMOV, KIND_OPQ: reg_bad = (s1_ra_r == NONE_REG) || (s1_rb_r == NONE_REG);
      KIND_IRMOV:          reg_bad = (s1_ra_r != NONE_REG);
      KIND_PUSH, KIND_POP: reg_bad = (s1_rb_r != NONE_REG);
      default:             reg_bad = 1'b0;
    endcase
    // Priority: pc outside memory, bad opcode, end past memory, registers
    if (pc_oob) begin
      s2_st_nxt = ST_ADR;
    end else if (!s1_info_r.op_ok) begin
      s2_st_nxt = ST_INS;
    end else if (end_oob) begin
      s2_st_nxt = ST_ADR;
    end else if (reg_bad) begin
      s2_st_nxt = ST_INS;
    end else if (s1_info_r.kind == KIND_HALT) begin
      s2_st_nxt = ST_HALT;
    end else begin
      s2_st_nxt = ST_OK;
    end
  end

  // ---------------- Stage 3: error masking ----------------
  always_comb begin
    out_v_nxt  = s2_v_r;
    out_st_nxt = s2_st_r;
    if (s2_st_r == ST_ADR || s2_st_r == ST_INS) begin
      out_kind_nxt = KIND_BAD;
      out_len_nxt  = '0;
      out_fn_nxt   = '0;
      out_ra_nxt   = '0;
      out_rb_nxt   = '0;
      out_cval_nxt = '0;
    end else begin
      out_kind_nxt = s2_kind_r;
      out_len_nxt  = s2_len_r;
      out_fn_nxt   = s2_fn_r;
      out_ra_nxt   = s2_ra_r;
      out_rb_nxt   = s2_rb_r;
      out_cval_nxt = s2_cval_r;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_en) s1_v_r  <= s1_v_nxt;
      if (s2_en) s2_v_r  <= s2_v_nxt;
      if (s3_en) out_v_r <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_pc_r   <= s1_pc_nxt;
      s1_info_r <= s1_info_nxt;
      s1_fn_r   <= s1_fn_nxt;
      s1_ra_r   <= s1_ra_nxt;
      s1_rb_r   <= s1_rb_nxt;
      s1_cval_r <= s1_cval_nxt;
    end
    if (s2_en) begin
      s2_kind_r <= s2_kind_nxt;
      s2_len_r  <= s2_len_nxt;
      s2_fn_r   <= s1_fn_r;
      s2_ra_r   <= s1_ra_r;
      s2_rb_r   <= s1_rb_r;
      s2_cval_r <= s1_cval_r;
      s2_st_r   <= s2_st_nxt;
    end
    if (s3_en) begin
      out_kind_r <= out_kind_nxt;
      out_len_r  <= out_len_nxt;
      out_fn_r   <= out_fn_nxt;
      out_ra_r   <= out_ra_nxt;
      out_rb_r   <= out_rb_nxt;
      out_cval_r <= out_cval_nxt;
      out_st_r   <= out_st_nxt;
    end
  end

  // Outputs
  assign out_valid     = out_v_r;
  assign out_kind      = out_kind_r;
  assign out_length    = out_len_r;
  assign out_func_code = out_fn_r;
  assign out_reg_a     = out_ra_r;
  assign out_reg_b     = out_rb_r;
  assign out_constant  = out_cval_r;
  assign out_status    = out_st_r;

endmodule

// ----- hw/rtl/y86dec_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86dec_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module y86dec_checker import y86dec_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_kind,
  input logic [3:0]  out_length,
  input logic [3:0]  out_func_code,
  input logic [3:0]  out_reg_a,
  input logic [3:0]  out_reg_b,
  input logic [63:0] out_constant,
  input logic [1:0]  out_status
);

  // Error results carry the invalid class and zeroed fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ADR || out_status == ST_INS) |->
      out_kind == KIND_BAD && out_length == 4'd0 && out_func_code == 4'd0 &&
      out_reg_a == 4'd0 && out_reg_b == 4'd0 && out_constant == 64'd0)
    else $error("error transaction with nonzero fields");

  // Halt status only for the halt class, one byte long
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_HALT |-> out_kind == KIND_HALT && out_length == LEN_1)
    else $error("halt status on wrong class or length");

  // OK status: a real, non-halt class with a nonzero length
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |->
      out_kind != KIND_HALT && out_kind != KIND_BAD && out_length != 4'd0)
    else $error("ok status on halt or invalid class");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_constant))
    else $error("stalled result changed");

  // Input backpressure only while a result is waiting on a stalled receiver
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

endmodule

bind y86_instruction_decode_unit y86dec_checker u_y86dec_checker (.*);
